// ===== hdl/efd_pkg.sv =====
//------------------------------------------------------------------------------
// efd_pkg: shared types and constants of the escaped frame deframer
// Control bytes, result kind codes, counter widths and the CRC-16 byte step.
//------------------------------------------------------------------------------
`default_nettype none

package efd_pkg;

   // frame size limit and derived widths
   localparam int MAX_FRAME_BYTES = 1024;
   localparam int COUNT_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int LEN_W = 11;
   localparam int LEN_MAX = (1 << LEN_W) - 1;
   localparam int EXT_W = (COUNT_W > LEN_W) ? COUNT_W : LEN_W;

   // line control bytes
   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_DLE = 8'h10;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   // result kinds
   localparam logic [1:0] KIND_DATA    = 2'd0;
   localparam logic [1:0] KIND_RESTART = 2'd1;
   localparam logic [1:0] KIND_GOOD    = 2'd2;
   localparam logic [1:0] KIND_BAD     = 2'd3;

   typedef struct packed {
      logic [1:0]       kind;
      logic [7:0]       data_byte;
      logic [LEN_W-1:0] frame_length;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } push_type;

   // one CRC-16/XMODEM byte step, MSB first
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/efd_channels.sv =====
//------------------------------------------------------------------------------
// efd channels: valid/ready interfaces of the deframer
// Request channel carries raw line bytes, response channel carries results.
//------------------------------------------------------------------------------
`default_nettype none

interface efd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface efd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  data_byte;
   logic [10:0] frame_length;

   modport source (output valid, output kind, output data_byte, output frame_length,
                   input ready);
   modport sink (input valid, input kind, input data_byte, input frame_length,
                 output ready);
endinterface

`default_nettype wire

// ===== hdl/efd_frame_core.sv =====
//------------------------------------------------------------------------------
// efd_frame_core: input register and frame state machine
// Registers each line byte, then decodes escapes and frame markers, keeps the
// running CRC and byte count, and pushes at most one result per item.
//------------------------------------------------------------------------------
`default_nettype none

module efd_frame_core (
   input  wire logic          clock,
   input  wire logic          reset,
   efd_req_if.sink            req_chan,
   input  wire logic          fifo_full,
   output efd_pkg::push_type  push
);
   import efd_pkg::*;

   // input register
   logic                s1_valid_ff, s1_valid_in;
   logic [7:0]          s1_byte_ff;
   logic                advance;

   // frame state
   logic                esc_ff, esc_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                ovf_ff, ovf_in;
   logic [7:0]          held0_ff, held0_in;
   logic [7:0]          held1_ff, held1_in;
   logic [15:0]         crc_ff, crc_in;

   logic [EXT_W-1:0]    count_ext;
   logic [LEN_W-1:0]    len_sat;
   logic                crc_match;
   logic                at_max;

   assign advance = s1_valid_ff && !fifo_full;
   assign req_chan.ready = !s1_valid_ff || !fifo_full;
   assign s1_valid_in = req_chan.ready ? req_chan.valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_chan.valid && req_chan.ready) begin
         s1_byte_ff <= req_chan.rx_byte;
      end
   end

   // frame length saturates at the width of the result field
   assign count_ext = EXT_W'(count_ff);
   assign len_sat = (count_ext > EXT_W'(LEN_MAX)) ? LEN_W'(LEN_MAX) : LEN_W'(count_ext);
   assign crc_match = ({held1_ff, held0_ff} == crc_ff);
   assign at_max = (count_ff == COUNT_W'(MAX_FRAME_BYTES));

   // decode one byte
   always_comb begin
      esc_in = esc_ff;
      count_in = count_ff;
      ovf_in = ovf_ff;
      held0_in = held0_ff;
      held1_in = held1_ff;
      crc_in = crc_ff;
      push = '0;
      if (advance) begin
         if (!esc_ff && s1_byte_ff == CH_DLE) begin
            esc_in = 1'b1;
         end else if (!esc_ff && s1_byte_ff == CH_SOH) begin
            count_in = '0;
            ovf_in = 1'b0;
            held0_in = '0;
            held1_in = '0;
            crc_in = '0;
            push.valid = 1'b1;
            push.item.kind = KIND_RESTART;
         end else if (!esc_ff && s1_byte_ff == CH_EOT) begin
            // short EOT is dropped without a result
            if (count_ff >= COUNT_W'(2)) begin
               push.valid = 1'b1;
               push.item.kind = (count_ff > COUNT_W'(2) && !ovf_ff && crc_match) ?
                                KIND_GOOD : KIND_BAD;
               push.item.frame_length = len_sat;
               count_in = '0;
               ovf_in = 1'b0;
               held0_in = '0;
               held1_in = '0;
               crc_in = '0;
            end
         end else begin
            // data byte, literal after DLE
            esc_in = 1'b0;
            if (count_ff >= COUNT_W'(2)) begin
               crc_in = crc16_byte(crc_ff, held0_ff);
            end
            held0_in = held1_ff;
            held1_in = s1_byte_ff;
            if (at_max) begin
               ovf_in = 1'b1;
            end else begin
               count_in = count_ff + COUNT_W'(1);
            end
            push.valid = 1'b1;
            push.item.kind = KIND_DATA;
            push.item.data_byte = s1_byte_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff <= 1'b0;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         held0_ff <= '0;
         held1_ff <= '0;
         crc_ff <= '0;
      end else begin
         esc_ff <= esc_in;
         count_ff <= count_in;
         ovf_ff <= ovf_in;
         held0_ff <= held0_in;
         held1_ff <= held1_in;
         crc_ff <= crc_in;
      end
   end

   // checks
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      push.valid && push.item.kind == KIND_RESTART |=> count_ff == '0 && !ovf_ff)
      else $error("frame state not cleared after restart");

   a_good_needs_length: assert property (@(posedge clock) disable iff (reset)
      push.valid && push.item.kind == KIND_GOOD |-> count_ff > COUNT_W'(2) && !ovf_ff)
      else $error("good frame reported with short length or overflow");

   a_ovf_at_max: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> at_max)
      else $error("overflow flag set below frame limit");

endmodule

`default_nettype wire

// ===== hdl/efd_rsp_fifo.sv =====
//------------------------------------------------------------------------------
// efd_rsp_fifo: two-entry result buffer
// Holds finished results so the input side keeps moving while the response
// side stalls; full is registered so no ready path crosses the block.
//------------------------------------------------------------------------------
`default_nettype none

module efd_rsp_fifo (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire efd_pkg::push_type push,
   output logic               fifo_full,
   efd_rsp_if.source          rsp_chan
);
   import efd_pkg::*;

   rsp_item_type  mem_ff [2];
   logic          wr_ptr_ff, rd_ptr_ff;
   logic [1:0]    count_ff, count_in;
   logic          pop;
   rsp_item_type  head;

   assign pop = rsp_chan.valid && rsp_chan.ready;
   assign fifo_full = (count_ff == 2'd2);
   assign head = mem_ff[rd_ptr_ff];

   assign rsp_chan.valid = (count_ff != 2'd0);
   assign rsp_chan.kind = head.kind;
   assign rsp_chan.data_byte = head.data_byte;
   assign rsp_chan.frame_length = head.frame_length;

   always_comb begin
      count_in = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push.valid && pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   // pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push.valid) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.item;
      end
   end

   // checks
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !fifo_full)
      else $error("result pushed into full buffer");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("buffer occupancy out of range");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("pointers disagree with occupancy");

endmodule

`default_nettype wire

// ===== hdl/escaped_frame_deframer_crc16_unit.sv =====
//------------------------------------------------------------------------------
// escaped_frame_deframer_crc16_unit: DLE-escaped frame deframer with CRC-16
// Unescapes line bytes, reports frame restarts and CRC-checked frame ends.
//
//   channel   dir  fields                              handshake
//   req_chan  in   rx_byte[7:0]                        valid/ready
//   rsp_chan  out  kind[1:0] data_byte[7:0]            valid/ready
//                  frame_length[10:0]
//
// One item per cycle sustained while the response side keeps taking results;
// a result is offered once its item has passed the input register and the
// frame logic has written it into the result buffer.
// Items that make no result (DLE, short EOT) pass through without a slot.
// Synchronous reset clears the frame state, the input stage and the buffer.
// A stalled response side fills the two-entry buffer and the input register,
// then the input stalls; full is registered, so a full buffer takes no push as it pops.
//------------------------------------------------------------------------------
`default_nettype none

module escaped_frame_deframer_crc16_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   efd_req_if.sink    req_chan,
   efd_rsp_if.source  rsp_chan
);
   import efd_pkg::*;

   push_type  push;
   logic      fifo_full;

   efd_frame_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .fifo_full (fifo_full),
      .push      (push)
   );

   efd_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .fifo_full (fifo_full),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire
